[rtl/itoa_pkg.sv]
// shared types, constants and helpers for the integer to ascii radix unit
package itoa_pkg;

    localparam int DEFAULT_WORD_WIDTH = 32;
    localparam int TYPE_W             = 3;
    localparam int VALUE_W            = 32;
    localparam int CHAR_W             = 7;

    // decimal path: binary to bcd over a fixed 32-bit input
    localparam int DEC_IN_W   = 32;
    localparam int DEC_DIGITS = 10;
    localparam int DEC_BITS   = DEC_DIGITS * 4;

    // format selector codes
    localparam logic [TYPE_W-1:0] FMT_OCT  = 3'd0;
    localparam logic [TYPE_W-1:0] FMT_HEXL = 3'd1;
    localparam logic [TYPE_W-1:0] FMT_HEXU = 3'd2;
    localparam logic [TYPE_W-1:0] FMT_UDEC = 3'd3;
    localparam logic [TYPE_W-1:0] FMT_SDEC = 3'd4;
    localparam logic [TYPE_W-1:0] FMT_BIN  = 3'd5;

    localparam logic [CHAR_W-1:0] CH_MINUS   = 7'd45;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 7'd48;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 7'd65;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 7'd97;

    typedef enum logic [1:0] {
        RADIX_BIN,
        RADIX_OCT,
        RADIX_HEX,
        RADIX_DEC
    } radix_t;

    typedef struct packed {
        radix_t radix;
        logic   upper;
        logic   neg;
    } emit_ctrl_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
        logic [CHAR_W-1:0] base;
        base = upper ? CH_UPPER_A : CH_LOWER_A;
        if (d < 4'd10)
        begin
            return CH_ZERO + {3'b000, d};
        end
        return base + {3'b000, d} - 7'd10;
    endfunction

endpackage

[rtl/integer_to_ascii_radix_unit.sv]
// integer to ascii radix unit: one item in, its characters out one per cycle while char_ready is high
// one item at a time; the next item is taken once the last digit has left the shifter
// hex, octal, binary: leading zero digits are skipped first, then the digits are sent
// decimal: the serial bcd converter runs first, then its result is skipped and sent the same way
// reset clears all control state; a pending output character is dropped
module integer_to_ascii_radix_unit #(
    parameter int WORD_WIDTH = itoa_pkg::DEFAULT_WORD_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  logic [itoa_pkg::TYPE_W-1:0]       req_type,
    input  logic [itoa_pkg::VALUE_W-1:0]      value,
    output logic                              char_valid,
    input  logic                              char_ready,
    output logic [itoa_pkg::CHAR_W-1:0]       char_out,
    output logic                              last
);

    localparam int OCT_DIGITS = (WORD_WIDTH + 2) / 3;
    localparam int OCT_BITS   = OCT_DIGITS * 3;
    localparam int HEX_DIGITS = (WORD_WIDTH + 3) / 4;
    localparam int HEX_BITS   = HEX_DIGITS * 4;
    localparam int DEC_W      = itoa_pkg::DEC_IN_W;
    localparam int DEC_BITS   = itoa_pkg::DEC_BITS;
    localparam int MAX_A      = (OCT_BITS > HEX_BITS) ? OCT_BITS : HEX_BITS;
    localparam int BUF_W      = (MAX_A > DEC_BITS) ? MAX_A : DEC_BITS;
    localparam int CNT_W      = $clog2(WORD_WIDTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_EMIT
    } state_t;

    state_t                       state_reg, state_next;
    itoa_pkg::emit_ctrl_t         pend_reg, pend_next;

    logic [WORD_WIDTH-1:0]        word;
    logic [WORD_WIDTH-1:0]        mag;
    logic [15:0]                  m16;
    logic                         accept;
    logic                         fmt_ok;
    logic                         is_dec;
    itoa_pkg::emit_ctrl_t         in_ctrl;
    logic [BUF_W-1:0]             in_digits;
    logic [CNT_W-1:0]             in_count;
    logic [DEC_W-1:0]             dec_in;

    logic                         bcd_busy;
    logic [DEC_BITS-1:0]          bcd;

    logic                         emit_load;
    logic                         emit_busy;
    itoa_pkg::emit_ctrl_t         emit_ctrl;
    logic [BUF_W-1:0]             emit_digits;
    logic [CNT_W-1:0]             emit_count;

    assign word   = WORD_WIDTH'(value);
    assign mag    = word[WORD_WIDTH-1] ? (~word + WORD_WIDTH'(1)) : word;
    assign m16    = word[15] ? (~word[15:0] + 16'd1) : word[15:0];
    assign accept = req_valid && req_ready;
    assign fmt_ok = req_type inside {[itoa_pkg::FMT_OCT:itoa_pkg::FMT_BIN]};

    // digits are placed at the top of the buffer, field padded to whole digits
    always_comb
    begin
        in_ctrl.radix = itoa_pkg::RADIX_HEX;
        in_ctrl.upper = 1'b0;
        in_ctrl.neg   = 1'b0;
        in_digits     = BUF_W'(word) << (BUF_W - HEX_BITS);
        in_count      = CNT_W'(HEX_DIGITS);
        dec_in        = DEC_W'(word);
        is_dec        = 1'b0;
        case (req_type)
            itoa_pkg::FMT_OCT:
            begin
                in_ctrl.radix = itoa_pkg::RADIX_OCT;
                in_ctrl.neg   = word[WORD_WIDTH-1];
                in_digits     = BUF_W'(mag) << (BUF_W - OCT_BITS);
                in_count      = CNT_W'(OCT_DIGITS);
            end
            itoa_pkg::FMT_HEXL:
            begin
                in_ctrl.radix = itoa_pkg::RADIX_HEX;
            end
            itoa_pkg::FMT_HEXU:
            begin
                in_ctrl.radix = itoa_pkg::RADIX_HEX;
                in_ctrl.upper = 1'b1;
            end
            itoa_pkg::FMT_UDEC:
            begin
                in_ctrl.radix = itoa_pkg::RADIX_DEC;
                is_dec        = 1'b1;
            end
            itoa_pkg::FMT_SDEC:
            begin
                in_ctrl.radix = itoa_pkg::RADIX_DEC;
                in_ctrl.neg   = word[15];
                dec_in        = DEC_W'(m16);
                is_dec        = 1'b1;
            end
            itoa_pkg::FMT_BIN:
            begin
                in_ctrl.radix = itoa_pkg::RADIX_BIN;
                in_digits     = BUF_W'(word) << (BUF_W - WORD_WIDTH);
                in_count      = CNT_W'(WORD_WIDTH);
            end
            default:
            begin
                in_ctrl.radix = itoa_pkg::RADIX_HEX;
            end
        endcase
    end

    itoa_bcd u_bcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept && fmt_ok && is_dec),
        .bin   (dec_in),
        .busy  (bcd_busy),
        .bcd   (bcd)
    );

    // decimal items load the shifter from the bcd result, others straight from the input
    always_comb
    begin
        if (state_reg == S_CONV)
        begin
            emit_load   = !bcd_busy;
            emit_ctrl   = pend_reg;
            emit_digits = BUF_W'(bcd) << (BUF_W - DEC_BITS);
            emit_count  = CNT_W'(itoa_pkg::DEC_DIGITS);
        end
        else
        begin
            emit_load   = accept && fmt_ok && !is_dec;
            emit_ctrl   = in_ctrl;
            emit_digits = in_digits;
            emit_count  = in_count;
        end
    end

    itoa_emit #(
        .BUF_W (BUF_W),
        .CNT_W (CNT_W)
    ) u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (emit_load),
        .ctrl       (emit_ctrl),
        .digits     (emit_digits),
        .count      (emit_count),
        .busy       (emit_busy),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_out   (char_out),
        .last       (last)
    );

    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg;
        case (state_reg)
            S_IDLE:
            begin
                // an unused selector is taken and produces nothing
                if (accept && fmt_ok)
                begin
                    pend_next  = in_ctrl;
                    state_next = is_dec ? S_CONV : S_EMIT;
                end
            end
            S_CONV:
            begin
                if (!bcd_busy)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!emit_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);

endmodule

[rtl/itoa_bcd.sv]
// serial binary to bcd converter, one input bit per cycle (shift and add three)
module itoa_bcd (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [itoa_pkg::DEC_IN_W-1:0]     bin,
    output logic                              busy,
    output logic [itoa_pkg::DEC_BITS-1:0]     bcd
);

    localparam int IN_W   = itoa_pkg::DEC_IN_W;
    localparam int DIGITS = itoa_pkg::DEC_DIGITS;
    localparam int BITS   = itoa_pkg::DEC_BITS;
    localparam int CNT_W  = $clog2(IN_W + 1);

    logic [IN_W-1:0]  bin_reg, bin_next;
    logic [BITS-1:0]  bcd_reg, bcd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [BITS-1:0]  adj;

    // each bcd digit of five or more gets three added before the shift
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
            begin
                adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            end
            else
            begin
                adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
            end
        end
    end

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            bin_next  = bin;
            bcd_next  = '0;
            cnt_next  = CNT_W'(IN_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            bcd_next = {adj[BITS-2:0], bin_reg[IN_W-1]};
            bin_next = {bin_reg[IN_W-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign busy = busy_reg;
    assign bcd  = bcd_reg;

endmodule

[rtl/itoa_emit.sv]
// digit shifter: drops leading zero digits, then sends one character per cycle while char_ready is high
module itoa_emit #(
    parameter int BUF_W = 66,
    parameter int CNT_W = 7
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  itoa_pkg::emit_ctrl_t           ctrl,
    input  logic [BUF_W-1:0]               digits,
    input  logic [CNT_W-1:0]               count,
    output logic                           busy,
    output logic                           char_valid,
    input  logic                           char_ready,
    output logic [itoa_pkg::CHAR_W-1:0]    char_out,
    output logic                           last
);

    typedef enum logic [1:0] {
        E_IDLE,
        E_SKIP,
        E_SEND
    } phase_t;

    phase_t                         phase_reg, phase_next;
    itoa_pkg::emit_ctrl_t           ctrl_reg, ctrl_next;
    logic [BUF_W-1:0]               buf_reg, buf_next;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic                           valid_reg, valid_next;
    logic [itoa_pkg::CHAR_W-1:0]    char_reg, char_next;
    logic                           last_reg, last_next;
    logic [3:0]                     dig;
    logic [BUF_W-1:0]               buf_shift;
    logic                           out_free;

    // top digit of the buffer and the buffer moved on by one digit
    always_comb
    begin
        case (ctrl_reg.radix)
            itoa_pkg::RADIX_BIN:
            begin
                dig       = {3'b000, buf_reg[BUF_W-1]};
                buf_shift = {buf_reg[BUF_W-2:0], 1'b0};
            end
            itoa_pkg::RADIX_OCT:
            begin
                dig       = {1'b0, buf_reg[BUF_W-1 -: 3]};
                buf_shift = {buf_reg[BUF_W-4:0], 3'b000};
            end
            default:
            begin
                dig       = buf_reg[BUF_W-1 -: 4];
                buf_shift = {buf_reg[BUF_W-5:0], 4'b0000};
            end
        endcase
    end

    assign out_free = !valid_reg || char_ready;

    always_comb
    begin
        phase_next = phase_reg;
        ctrl_next  = ctrl_reg;
        buf_next   = buf_reg;
        cnt_next   = cnt_reg;
        valid_next = valid_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        if (char_ready)
        begin
            valid_next = 1'b0;
        end
        case (phase_reg)
            E_IDLE:
            begin
                if (load)
                begin
                    ctrl_next  = ctrl;
                    buf_next   = digits;
                    cnt_next   = count;
                    phase_next = E_SKIP;
                end
            end
            E_SKIP:
            begin
                // keep at least one digit so zero still prints
                if (dig == 4'd0 && cnt_reg > CNT_W'(1))
                begin
                    buf_next = buf_shift;
                    cnt_next = cnt_reg - CNT_W'(1);
                end
                else
                begin
                    phase_next = E_SEND;
                end
            end
            E_SEND:
            begin
                if (out_free)
                begin
                    valid_next = 1'b1;
                    if (ctrl_reg.neg)
                    begin
                        char_next     = itoa_pkg::CH_MINUS;
                        last_next     = 1'b0;
                        ctrl_next.neg = 1'b0;
                    end
                    else
                    begin
                        char_next = itoa_pkg::digit_char(dig, ctrl_reg.upper);
                        last_next = (cnt_reg == CNT_W'(1));
                        buf_next  = buf_shift;
                        cnt_next  = cnt_reg - CNT_W'(1);
                        if (cnt_reg == CNT_W'(1))
                        begin
                            phase_next = E_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                phase_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= E_IDLE;
            ctrl_reg  <= '0;
            buf_reg   <= '0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
            char_reg  <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            ctrl_reg  <= ctrl_next;
            buf_reg   <= buf_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
            char_reg  <= char_next;
            last_reg  <= last_next;
        end
    end

    assign busy       = (phase_reg != E_IDLE);
    assign char_valid = valid_reg;
    assign char_out   = char_reg;
    assign last       = last_reg;

endmodule

[bench/tb.sv]
// self-checking testbench for the integer to ascii radix unit
module tb;

    localparam int TYPE_W       = itoa_pkg::TYPE_W;
    localparam int VALUE_W      = itoa_pkg::VALUE_W;
    localparam int CHAR_W       = itoa_pkg::CHAR_W;
    localparam int LONG_HOLD    = 300;    // receiver hold-off to back up the input
    localparam int HOLD_AT_ITEM = 120;
    localparam int QUIET_TAIL   = 40;     // last pending items run with no idling
    localparam int RANDOM_ITEMS = 405;
    localparam int DRAIN_CYCLES = 100;
    localparam int LIMIT_TIME   = 13_000_000;

    typedef struct packed {
        logic [TYPE_W-1:0]  fmt;
        logic [VALUE_W-1:0] val;
    } conv_req_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              is_last;
    } ascii_char_t;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               req_valid  = 1'b0;
    logic               req_ready;
    logic [TYPE_W-1:0]  req_type   = '0;
    logic [VALUE_W-1:0] value      = '0;
    logic               char_valid;
    logic               char_ready = 1'b0;
    logic [CHAR_W-1:0]  char_out;
    logic               last;

    conv_req_t   pending_reqs[$];
    ascii_char_t expected_chars[$];
    conv_req_t   next_req;

    int issued_items   = 0;
    int accepted_items = 0;
    int send_gap       = 0;
    int stall_left     = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;
    int errors         = 0;
    int chars_checked  = 0;
    int fmt_seen[8]    = '{default: 0};

    integer_to_ascii_radix_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_type   (req_type),
        .value      (value),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_out   (char_out),
        .last       (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // expected characters of one accepted item, most significant digit first
    task automatic predict_digits(input logic [TYPE_W-1:0] fmt,
                                  input logic [VALUE_W-1:0] val);
        logic [31:0]       mag;
        logic [31:0]       radix;
        logic              upper;
        logic              neg;
        logic [CHAR_W-1:0] digs[$];
        logic [3:0]        d;
        upper = 1'b0;
        neg   = 1'b0;
        mag   = val;
        case (fmt)
            itoa_pkg::FMT_OCT:
            begin
                radix = 8;
                neg   = val[31];
                mag   = neg ? (32'd0 - val) : val;
            end
            itoa_pkg::FMT_HEXL: radix = 16;
            itoa_pkg::FMT_HEXU:
            begin
                radix = 16;
                upper = 1'b1;
            end
            itoa_pkg::FMT_UDEC: radix = 10;
            itoa_pkg::FMT_SDEC:
            begin
                radix = 10;
                neg   = val[15];
                mag   = {16'd0, neg ? (16'd0 - val[15:0]) : val[15:0]};
            end
            itoa_pkg::FMT_BIN:  radix = 2;
            default:  return;   // unused selectors produce nothing
        endcase
        do
        begin
            d = 4'(mag % radix);
            if (d < 4'd10)
                digs.push_front(itoa_pkg::CH_ZERO + CHAR_W'(d));
            else
                digs.push_front((upper ? itoa_pkg::CH_UPPER_A : itoa_pkg::CH_LOWER_A)
                                + CHAR_W'(d) - 7'd10);
            mag = mag / radix;
        end
        while (mag != 0);
        if (neg)
            expected_chars.push_back('{ch: itoa_pkg::CH_MINUS, is_last: 1'b0});
        foreach (digs[i])
            expected_chars.push_back('{ch: digs[i], is_last: (i == digs.size() - 1)});
    endtask

    // quiet windows: every third block of 50 items, and the tail of the run
    function automatic bit idling_allowed();
        return (pending_reqs.size() >= QUIET_TAIL) && ((accepted_items / 50) % 3 != 2);
    endfunction

    // request driver
    always @(negedge clk)
    begin
        if (!rst_n)
            req_valid <= 1'b0;
        else if (issued_items != accepted_items)
            ;   // item still on offer
        else if (send_gap != 0)
        begin
            req_valid <= 1'b0;
            send_gap  <= send_gap - 1;
        end
        else if (pending_reqs.size() != 0)
        begin
            next_req     = pending_reqs.pop_front();
            req_type     <= next_req.fmt;
            value        <= next_req.val;
            req_valid    <= 1'b1;
            issued_items <= issued_items + 1;
            if (idling_allowed() && $urandom_range(0, 3) == 0)
                send_gap <= $urandom_range(1, 19);
        end
        else
            req_valid <= 1'b0;
    end

    // long receiver hold-off so the unit backs up and stalls its input
    always @(negedge clk)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (!hold_done && accepted_items == HOLD_AT_ITEM)
        begin
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // character receiver
    always @(negedge clk)
    begin
        if (!rst_n)
            char_ready <= 1'b0;
        else if (hold_left != 0)
            char_ready <= 1'b0;
        else if (stall_left != 0)
        begin
            char_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            char_ready <= 1'b1;
            if (idling_allowed() && $urandom_range(0, 7) == 0)
                stall_left <= $urandom_range(1, 19);
        end
    end

    // accepted items feed the predictor, accepted characters are checked in order
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                predict_digits(req_type, value);
                fmt_seen[req_type] = fmt_seen[req_type] + 1;
                accepted_items <= accepted_items + 1;
            end
            if (char_valid && char_ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    errors = errors + 1;
                    if (errors <= 10)
                        $display("unexpected char 0x%02h last %0b", char_out, last);
                end
                else
                begin
                    chars_checked = chars_checked + 1;
                    if (char_out !== expected_chars[0].ch
                        || last !== expected_chars[0].is_last)
                    begin
                        errors = errors + 1;
                        if (errors <= 10)
                            $display("mismatch: expected char 0x%02h last %0b, got 0x%02h last %0b",
                                     expected_chars[0].ch, expected_chars[0].is_last,
                                     char_out, last);
                    end
                    void'(expected_chars.pop_front());
                end
            end
        end
    end

    initial
    begin
        #LIMIT_TIME;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int          made;
        logic [2:0]  fmt;
        logic [31:0] val;
        int          r;

        // directed: zeros, extremes, sign boundaries, letter case, unused selectors
        pending_reqs.push_back('{fmt: itoa_pkg::FMT_OCT,  val: 32'h0000_0000});
        pending_reqs.push_back('{fmt: itoa_pkg::FMT_OCT,  val: 32'h7FFF_FFFF});
        pending_reqs.push_back('{fmt: itoa_pkg::FMT_OCT,  val: 32'h8000_0000});
        pending_reqs.push_back('{fmt: itoa_pkg::FMT_OCT,  val: 32'hFFFF_FFFF});
        pending_reqs.push_back('{fmt: itoa_pkg::FMT_HEXL, val: 32'h0000_0000});
        pending_reqs.push_back('{fmt: itoa_pkg::FMT_HEXL, val: 32'hABCD_EF01});
        pending_reqs.push_back('{fmt: itoa_pkg::FMT_HEXL, val: 32'hFFFF_FFFF});
        pending_reqs.push_back('{fmt: itoa_pkg::FMT_HEXU, val: 32'h0000_0000});
        pending_reqs.push_back('{fmt: itoa_pkg::FMT_HEXU, val: 32'hABCD_EF01});
        pending_reqs.push_back('{fmt: itoa_pkg::FMT_HEXU, val: 32'h8000_0000});
        pending_reqs.push_back('{fmt: itoa_pkg::FMT_UDEC, val: 32'h0000_0000});
        pending_reqs.push_back('{fmt: itoa_pkg::FMT_UDEC, val: 32'hFFFF_FFFF});
        pending_reqs.push_back('{fmt: itoa_pkg::FMT_UDEC, val: 32'h8000_0000});
        pending_reqs.push_back('{fmt: itoa_pkg::FMT_SDEC, val: 32'h0000_0000});
        pending_reqs.push_back('{fmt: itoa_pkg::FMT_SDEC, val: 32'h0000_7FFF});
        pending_reqs.push_back('{fmt: itoa_pkg::FMT_SDEC, val: 32'h0000_8000});
        pending_reqs.push_back('{fmt: itoa_pkg::FMT_SDEC, val: 32'h0000_FFFF});
        // upper half ignored
        pending_reqs.push_back('{fmt: itoa_pkg::FMT_SDEC, val: 32'hFFFF_0000});
        pending_reqs.push_back('{fmt: itoa_pkg::FMT_SDEC, val: 32'h1234_8001});
        pending_reqs.push_back('{fmt: itoa_pkg::FMT_BIN,  val: 32'h0000_0000});
        pending_reqs.push_back('{fmt: itoa_pkg::FMT_BIN,  val: 32'h0000_0001});
        pending_reqs.push_back('{fmt: itoa_pkg::FMT_BIN,  val: 32'hFFFF_FFFF});
        pending_reqs.push_back('{fmt: itoa_pkg::FMT_BIN,  val: 32'h8000_0000});
        pending_reqs.push_back('{fmt: 3'd6,               val: 32'hFFFF_FFFF});
        pending_reqs.push_back('{fmt: 3'd7,               val: 32'h0000_0000});

        made = 0;
        while (made < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 19);
            fmt = (r < 18) ? 3'(r % 6) : ((r == 18) ? 3'd6 : 3'd7);
            case ($urandom_range(0, 3))
                0: val = $urandom;
                1: val = $urandom_range(0, 20);
                2: val = $urandom >> $urandom_range(0, 31);
                default:
                begin
                    case ($urandom_range(0, 3))
                        0: val = 32'hFFFF_FFFF - $urandom_range(0, 3);
                        1: val = 32'h8000_0000 + $urandom_range(0, 3) - 2;
                        2: val = {16'($urandom_range(0, 65535)), 16'h8000}
                                 + $urandom_range(0, 2) - 1;
                        default: val = ~($urandom >> $urandom_range(0, 31));
                    endcase
                end
            endcase
            pending_reqs.push_back('{fmt: fmt, val: val});
            made = made + 1;
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_reqs.size() != 0 || issued_items != accepted_items
               || expected_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_chars.size() != 0)
        begin
            errors = errors + expected_chars.size();
            $display("%0d expected chars never arrived", expected_chars.size());
        end

        $display("covered %0d items: oct %0d, hex lower %0d, hex upper %0d, udec %0d, sdec %0d,",
                 accepted_items, fmt_seen[itoa_pkg::FMT_OCT], fmt_seen[itoa_pkg::FMT_HEXL],
                 fmt_seen[itoa_pkg::FMT_HEXU], fmt_seen[itoa_pkg::FMT_UDEC],
                 fmt_seen[itoa_pkg::FMT_SDEC]);
        $display("  bin %0d, unused %0d; %0d chars checked, %0d errors, long output hold applied",
                 fmt_seen[itoa_pkg::FMT_BIN], fmt_seen[6] + fmt_seen[7], chars_checked, errors);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
